>>> design/nnua_pkg.sv
// Shared constants, command codes and defaults of the NNUE accumulator.
// No dependencies; every other file of the block refers to it.
package nnua_pkg;

  // Board geometry and memory word layout.
  localparam int SQUARES = 64;
  localparam int LANES = 8;
  localparam int LANE_BITS = 3;
  localparam int SUM_WIDTH = 32;

  // Defaults of the top level parameters.
  localparam int HIDDEN_SIZE_DEF = 256;
  localparam int PIECE_TYPES_DEF = 6;
  localparam int WEIGHT_WIDTH_DEF = 16;

  // Field widths of the command channel.
  localparam int CMD_W = 3;
  localparam int PIECE_W = 3;
  localparam int SQ_W = 6;
  localparam int LANE_W = 8;
  localparam int WVAL_W = 16;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MOVE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ = 3'd5;

endpackage

>>> design/nnua_if.sv
// Valid/ready channel interfaces of the NNUE accumulator: commands in, sums out.
// Depends on nnua_pkg for the field widths.
interface nnua_cmd_if;
  logic                                   valid;
  logic                                   ready;
  logic [nnua_pkg::CMD_W-1:0]             command;
  logic                                   color;
  logic [nnua_pkg::PIECE_W-1:0]           piece;
  logic [nnua_pkg::SQ_W-1:0]              square;
  logic [nnua_pkg::SQ_W-1:0]              to_square;
  logic [nnua_pkg::LANE_W-1:0]            lane;
  logic signed [nnua_pkg::WVAL_W-1:0]     weight_value;

  modport source (output valid, command, color, piece, square, to_square, lane,
                  weight_value, input ready);
  modport sink (input valid, command, color, piece, square, to_square, lane,
                weight_value, output ready);
endinterface

interface nnua_res_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [nnua_pkg::SUM_WIDTH-1:0]  sum_value;

  modport source (output valid, sum_value, input ready);
  modport sink (input valid, sum_value, output ready);
endinterface

>>> design/nnua_weight_mem.sv
// Weight memory: one bank per lane of a word, one write and two read ports.
// Depends on nnua_pkg for the lane count.
module nnua_weight_mem #(
  parameter int DEPTH = 2,
  parameter int WEIGHT_WIDTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                                              clk_i,
  input  logic                                              wr_en_i,
  input  logic [nnua_pkg::LANE_BITS-1:0]                    wr_bank_i,
  input  logic [AW-1:0]                                     wr_addr_i,
  input  logic [WEIGHT_WIDTH-1:0]                           wr_data_i,
  input  logic                                              rd_en_i,
  input  logic [AW-1:0]                                     rd_addr_a_i,
  input  logic [AW-1:0]                                     rd_addr_b_i,
  output logic [nnua_pkg::LANES-1:0][WEIGHT_WIDTH-1:0]      rd_data_a_o,
  output logic [nnua_pkg::LANES-1:0][WEIGHT_WIDTH-1:0]      rd_data_b_o
);

  for (genvar b = 0; b < nnua_pkg::LANES; b++) begin : g_bank
    logic [WEIGHT_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk_i) begin
      if (wr_en_i && (wr_bank_i == nnua_pkg::LANE_BITS'(b))) begin
        mem[wr_addr_i] <= wr_data_i;
      end
      if (rd_en_i) begin
        rd_data_a_o[b] <= mem[rd_addr_a_i];
        rd_data_b_o[b] <= mem[rd_addr_b_i];
      end
    end
  end

endmodule

>>> design/nnua_sum_mem.sv
// Accumulator memory: words of eight 32-bit sums, with a valid bit per word
// so that reset and clear take effect at once. Depends on nnua_pkg.
module nnua_sum_mem #(
  parameter int WORDS = 32,
  parameter int AW = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                clear_i,
  input  logic                                                wr_en_i,
  input  logic [AW-1:0]                                       wr_addr_i,
  input  logic [nnua_pkg::LANES-1:0][nnua_pkg::SUM_WIDTH-1:0] wr_data_i,
  input  logic                                                rd_en_i,
  input  logic [AW-1:0]                                       rd_addr_i,
  output logic [nnua_pkg::LANES-1:0][nnua_pkg::SUM_WIDTH-1:0] rd_data_o
);

  logic [nnua_pkg::LANES-1:0][nnua_pkg::SUM_WIDTH-1:0] mem [WORDS];
  logic [nnua_pkg::LANES-1:0][nnua_pkg::SUM_WIDTH-1:0] rd_data_q;
  logic [WORDS-1:0] valid_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // A word that was never written since the last clear reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (clear_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

>>> design/nnue_accumulator_update.sv
// Top level of the NNUE incremental accumulator: command sequencer, update lanes
// and result register. Depends on nnua_pkg, nnua_if, nnua_weight_mem, nnua_sum_mem.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+----------------------------------------
//   cmd_i    | in  | valid/ready        | command, color, piece, square,
//            |     |                    | to_square, lane, weight_value
//   res_o    | out | valid/ready        | sum_value (one item per read command)
//
// Clear, write weight and the unused commands leave the sequencer idle, as do an add,
// remove or move with a piece past the last type. Add, remove and move otherwise walk
// the row in words of eight lanes: the accepting cycle, one accumulator read per word
// and the write-back of the last word. A read is held in ST_READ until res_o can take its sum.
// Reset clears the valid bits of the accumulator words at once, so every sum
// reads as zero right after reset; the weight memory is not reset.
// A pending result in res_o holds the next read in the sequencer until res_o
// frees up, and every later command waits behind that read.

module nnue_accumulator_update #(
  parameter int HIDDEN_SIZE = nnua_pkg::HIDDEN_SIZE_DEF,
  parameter int PIECE_TYPES = nnua_pkg::PIECE_TYPES_DEF,
  parameter int WEIGHT_WIDTH = nnua_pkg::WEIGHT_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  nnua_cmd_if.sink   cmd_i,
  nnua_res_if.source res_o
);

  // Memory geometry. Each accumulator word and each weight word holds eight lanes.
  localparam int WORDS = (HIDDEN_SIZE + nnua_pkg::LANES - 1) / nnua_pkg::LANES;
  localparam int WA = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int ROWS = 2 * PIECE_TYPES * nnua_pkg::SQUARES;
  localparam int ROW_W = $clog2(ROWS);
  localparam int BANK_DEPTH = ROWS * WORDS;
  localparam int WAW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int SW = nnua_pkg::SUM_WIDTH;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  logic [1:0] state_q, state_d;

  // Command fields held for a row walk or a read.
  logic [nnua_pkg::CMD_W-1:0]     op_q, op_d;
  logic [WAW-1:0]                 base_a_q, base_a_d;
  logic [WAW-1:0]                 base_b_q, base_b_d;
  logic [WA-1:0]                  cnt_q, cnt_d;
  logic [nnua_pkg::LANE_BITS-1:0] lane_sel_q, lane_sel_d;
  logic                           lane_ok_q, lane_ok_d;

  // Write-back stage: the word read in the previous cycle.
  logic          p1_q, p1_d;
  logic [WA-1:0] p1_addr_q, p1_addr_d;

  // Result register.
  logic          res_valid_q, res_valid_d;
  logic [SW-1:0] res_data_q, res_data_d;

  // Decoded command.
  logic            accept;
  logic            piece_ok;
  logic            lane_ok;
  logic [ROW_W-1:0] row_from, row_to;
  logic [WA-1:0]   lane_word;
  logic [WAW-1:0]  wr_word_addr;
  logic [31:0]     wval_ext;

  // Memory ports.
  logic                                   sum_clear;
  logic                                   sum_rd_en;
  logic [WA-1:0]                          sum_rd_addr;
  logic                                   sum_wr_en;
  logic [nnua_pkg::LANES-1:0][SW-1:0]     sum_rd_data;
  logic [nnua_pkg::LANES-1:0][SW-1:0]     sum_wr_data;
  logic                                   w_wr_en;
  logic                                   w_rd_en;
  logic [nnua_pkg::LANES-1:0][WEIGHT_WIDTH-1:0] w_rd_a, w_rd_b;

  logic res_load;

  assign cmd_i.ready = (state_q == ST_IDLE) && !p1_q;
  assign accept = cmd_i.valid && cmd_i.ready;

  assign piece_ok = 32'(cmd_i.piece) < PIECE_TYPES;
  assign lane_ok = 32'(cmd_i.lane) < HIDDEN_SIZE;
  assign lane_word = WA'(32'(cmd_i.lane) >> nnua_pkg::LANE_BITS);

  // Feature row number: (color * PIECE_TYPES + piece) * SQUARES + square.
  assign row_from = ROW_W'(((32'(cmd_i.color) * PIECE_TYPES) + 32'(cmd_i.piece))
                           * nnua_pkg::SQUARES + 32'(cmd_i.square));
  assign row_to = ROW_W'(((32'(cmd_i.color) * PIECE_TYPES) + 32'(cmd_i.piece))
                         * nnua_pkg::SQUARES + 32'(cmd_i.to_square));

  assign wr_word_addr = WAW'(32'(row_from) * WORDS + 32'(lane_word));

  // The 16-bit weight is sign extended, then its low WEIGHT_WIDTH bits are kept.
  assign wval_ext = 32'(cmd_i.weight_value);

  assign sum_clear = accept && (cmd_i.command == nnua_pkg::CMD_CLEAR);
  assign w_wr_en = accept && (cmd_i.command == nnua_pkg::CMD_WRITE) && piece_ok && lane_ok;

  // The accumulator is read at a read command and at every step of a row walk.
  assign sum_rd_en = (accept && (cmd_i.command == nnua_pkg::CMD_READ))
                   || (state_q == ST_RUN);
  assign sum_rd_addr = (state_q == ST_RUN) ? cnt_q : lane_word;
  assign w_rd_en = (state_q == ST_RUN);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    base_a_d   = base_a_q;
    base_b_d   = base_b_q;
    cnt_d      = cnt_q;
    lane_sel_d = lane_sel_q;
    lane_ok_d  = lane_ok_q;
    p1_d       = 1'b0;
    p1_addr_d  = p1_addr_q;
    res_load   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d = cmd_i.command;
          case (cmd_i.command)
            nnua_pkg::CMD_ADD, nnua_pkg::CMD_REMOVE: begin
              if (piece_ok) begin
                base_a_d = WAW'(32'(row_from) * WORDS);
                base_b_d = WAW'(32'(row_from) * WORDS);
                cnt_d    = '0;
                state_d  = ST_RUN;
              end
            end
            nnua_pkg::CMD_MOVE: begin
              // Port A walks the destination row, port B the origin row.
              if (piece_ok) begin
                base_a_d = WAW'(32'(row_to) * WORDS);
                base_b_d = WAW'(32'(row_from) * WORDS);
                cnt_d    = '0;
                state_d  = ST_RUN;
              end
            end
            nnua_pkg::CMD_READ: begin
              lane_sel_d = cmd_i.lane[nnua_pkg::LANE_BITS-1:0];
              lane_ok_d  = lane_ok;
              state_d    = ST_READ;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        p1_d      = 1'b1;
        p1_addr_d = cnt_q;
        if (cnt_q == WA'(WORDS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + WA'(1);
        end
      end
      ST_READ: begin
        // The read word stays in the memory output register until the result
        // register is free.
        if (!res_valid_q || res_o.ready) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Update lanes: add, subtract, or add the destination and subtract the origin.
  always_comb begin
    logic [SW-1:0] s, a, b, t;
    for (int i = 0; i < nnua_pkg::LANES; i++) begin
      s = sum_rd_data[i];
      a = SW'($signed(w_rd_a[i]));
      b = SW'($signed(w_rd_b[i]));
      t = (op_q == nnua_pkg::CMD_REMOVE) ? (s - a) : (s + a);
      sum_wr_data[i] = (op_q == nnua_pkg::CMD_MOVE) ? (t - b) : t;
    end
  end

  assign sum_wr_en = p1_q;

  always_comb begin
    res_valid_d = res_valid_q;
    res_data_d  = res_data_q;
    if (res_load) begin
      res_valid_d = 1'b1;
      res_data_d  = lane_ok_q ? sum_rd_data[lane_sel_q] : '0;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.sum_value = res_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      p1_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      p1_q        <= p1_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    base_a_q   <= base_a_d;
    base_b_q   <= base_b_d;
    cnt_q      <= cnt_d;
    lane_sel_q <= lane_sel_d;
    lane_ok_q  <= lane_ok_d;
    p1_addr_q  <= p1_addr_d;
    res_data_q <= res_data_d;
  end

  nnua_weight_mem #(
    .DEPTH        (BANK_DEPTH),
    .WEIGHT_WIDTH (WEIGHT_WIDTH),
    .AW           (WAW)
  ) u_weight_mem (
    .clk_i       (clk_i),
    .wr_en_i     (w_wr_en),
    .wr_bank_i   (cmd_i.lane[nnua_pkg::LANE_BITS-1:0]),
    .wr_addr_i   (wr_word_addr),
    .wr_data_i   (wval_ext[WEIGHT_WIDTH-1:0]),
    .rd_en_i     (w_rd_en),
    .rd_addr_a_i (base_a_q + WAW'(cnt_q)),
    .rd_addr_b_i (base_b_q + WAW'(cnt_q)),
    .rd_data_a_o (w_rd_a),
    .rd_data_b_o (w_rd_b)
  );

  nnua_sum_mem #(
    .WORDS (WORDS),
    .AW    (WA)
  ) u_sum_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (sum_clear),
    .wr_en_i   (sum_wr_en),
    .wr_addr_i (p1_addr_q),
    .wr_data_i (sum_wr_data),
    .rd_en_i   (sum_rd_en),
    .rd_addr_i (sum_rd_addr),
    .rd_data_o (sum_rd_data)
  );

`ifndef SYNTHESIS
  // The write-back stage only follows a step of a row walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_q |-> $past(state_q == ST_RUN))
    else $error("write-back without a preceding row walk step");

  // A word is never read in the cycle in which it is written back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sum_wr_en && sum_rd_en && (sum_rd_addr == p1_addr_q)))
    else $error("accumulator read and write collide on one word");

  // A new result only comes from a read command waiting for the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(state_q == ST_READ))
    else $error("result produced outside a read");
`endif

endmodule

>>> verif/testbench.sv
// Self-checking testbench of nnue_accumulator_update: weight rows, directed commands, random traffic.
// Depends on nnua_pkg and nnua_if from the design folder and on the block's top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import nnua_pkg::*;

  // The block is built with its default sizes, and the checker uses the same ones.
  localparam int HIDDEN = HIDDEN_SIZE_DEF;
  localparam int PIECES = PIECE_TYPES_DEF;
  localparam int WWIDTH = WEIGHT_WIDTH_DEF;

  // The two command codes that the block must accept and ignore.
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam int SCRIPT_LEN = 25;
  localparam int RANDOM_PER_PHASE = 75;
  localparam int FULL_ROWS = 4;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT = 200000;

  // Marks whether a read in the directed table has its answer written into the table.
  localparam bit TYPED = 1'b1;
  localparam bit PREDICTED = 1'b0;

  typedef struct {
    logic [CMD_W-1:0]          command;
    logic                      color;
    logic [PIECE_W-1:0]        piece;
    logic [SQ_W-1:0]           square;
    logic [SQ_W-1:0]           to_square;
    logic [LANE_W-1:0]         lane;
    logic signed [WVAL_W-1:0]  weight_value;
  } acc_cmd_t;

  typedef struct {
    acc_cmd_t                     cmd;
    bit                           fixed;
    logic signed [SUM_WIDTH-1:0]  sum;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;

  nnua_cmd_if cmd_bus ();
  nnua_res_if res_bus ();

  nnue_accumulator_update #(
    .HIDDEN_SIZE  (HIDDEN),
    .PIECE_TYPES  (PIECES),
    .WEIGHT_WIDTH (WWIDTH)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_bus.sink),
    .res_o  (res_bus.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Checker state: the accumulator sums and every weight written so far, keyed by the
  // flat index of the weight (feature row times HIDDEN plus lane).
  int acc_model [HIDDEN];
  int weight_model [int];

  // Sums that the block still owes, oldest first.
  logic signed [SUM_WIDTH-1:0] pending_sums [$];
  logic signed [SUM_WIDTH-1:0] expected_sum;

  int error_count = 0;
  int cycle_count = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  // Feature rows that are written in full before any add, remove or move touches them.
  // The third and fourth rows share color and piece, so a move can go between them.
  logic               full_color  [FULL_ROWS] = '{1'b0, 1'b1, 1'b0, 1'b0};
  logic [PIECE_W-1:0] full_piece  [FULL_ROWS] = '{3'd0, 3'd5, 3'd2, 3'd2};
  logic [SQ_W-1:0]    full_square [FULL_ROWS] = '{6'd0, 6'd63, 6'd21, 6'd42};

  // Directed commands. The weight setup below puts 32767 in lane 0 of the first full row
  // and -32768 in lane 255 of the second, so a few sums can be written in by hand.
  script_row_t script [SCRIPT_LEN] = '{
    // Sums read zero after reset.
    '{'{CMD_READ,    1'b0, 3'd0, 6'd0,  6'd0,  8'd0,   16'h0000}, TYPED,     32'sd0},
    '{'{CMD_READ,    1'b0, 3'd0, 6'd0,  6'd0,  8'd255, 16'h0000}, TYPED,     32'sd0},
    // One add of a row with a largest weight, then a clear.
    '{'{CMD_ADD,     1'b0, 3'd0, 6'd0,  6'd0,  8'd0,   16'h0000}, PREDICTED, 32'sd0},
    '{'{CMD_READ,    1'b0, 3'd0, 6'd0,  6'd0,  8'd0,   16'h0000}, TYPED,     32'sd32767},
    '{'{CMD_CLEAR,   1'b0, 3'd0, 6'd0,  6'd0,  8'd0,   16'h0000}, PREDICTED, 32'sd0},
    '{'{CMD_READ,    1'b0, 3'd0, 6'd0,  6'd0,  8'd0,   16'h0000}, TYPED,     32'sd0},
    // Removing the most negative weight from zero.
    '{'{CMD_REMOVE,  1'b1, 3'd5, 6'd63, 6'd0,  8'd0,   16'h0000}, PREDICTED, 32'sd0},
    '{'{CMD_READ,    1'b0, 3'd0, 6'd0,  6'd0,  8'd255, 16'h0000}, TYPED,     32'sd32768},
    // Pieces past the last piece type change nothing.
    '{'{CMD_ADD,     1'b0, 3'd6, 6'd0,  6'd0,  8'd0,   16'h0000}, PREDICTED, 32'sd0},
    '{'{CMD_REMOVE,  1'b1, 3'd7, 6'd63, 6'd0,  8'd0,   16'h0000}, PREDICTED, 32'sd0},
    '{'{CMD_MOVE,    1'b0, 3'd6, 6'd21, 6'd42, 8'd0,   16'h0000}, PREDICTED, 32'sd0},
    '{'{CMD_WRITE,   1'b1, 3'd7, 6'd63, 6'd0,  8'd255, 16'h7fff}, PREDICTED, 32'sd0},
    '{'{CMD_READ,    1'b0, 3'd0, 6'd0,  6'd0,  8'd255, 16'h0000}, TYPED,     32'sd32768},
    // A real move, then a move onto the same square.
    '{'{CMD_MOVE,    1'b0, 3'd2, 6'd21, 6'd42, 8'd0,   16'h0000}, PREDICTED, 32'sd0},
    '{'{CMD_READ,    1'b0, 3'd0, 6'd0,  6'd0,  8'd0,   16'h0000}, PREDICTED, 32'sd0},
    '{'{CMD_READ,    1'b0, 3'd0, 6'd0,  6'd0,  8'd255, 16'h0000}, PREDICTED, 32'sd0},
    '{'{CMD_MOVE,    1'b0, 3'd2, 6'd42, 6'd42, 8'd0,   16'h0000}, PREDICTED, 32'sd0},
    '{'{CMD_READ,    1'b0, 3'd0, 6'd0,  6'd0,  8'd100, 16'h0000}, PREDICTED, 32'sd0},
    // The unused codes, with every field bit set.
    '{'{CMD_SPARE_6, 1'b1, 3'd7, 6'd63, 6'd63, 8'd255, 16'hffff}, PREDICTED, 32'sd0},
    '{'{CMD_SPARE_7, 1'b1, 3'd7, 6'd63, 6'd63, 8'd255, 16'hffff}, PREDICTED, 32'sd0},
    // Overwriting a weight that is in use.
    '{'{CMD_WRITE,   1'b0, 3'd0, 6'd0,  6'd0,  8'd0,   16'h8000}, PREDICTED, 32'sd0},
    '{'{CMD_ADD,     1'b0, 3'd0, 6'd0,  6'd0,  8'd0,   16'h0000}, PREDICTED, 32'sd0},
    '{'{CMD_READ,    1'b0, 3'd0, 6'd0,  6'd0,  8'd0,   16'h0000}, PREDICTED, 32'sd0},
    '{'{CMD_CLEAR,   1'b0, 3'd0, 6'd0,  6'd0,  8'd0,   16'h0000}, PREDICTED, 32'sd0},
    '{'{CMD_READ,    1'b0, 3'd0, 6'd0,  6'd0,  8'd128, 16'h0000}, TYPED,     32'sd0}
  };

  function automatic int row_base(logic color, logic [PIECE_W-1:0] piece,
                                  logic [SQ_W-1:0] square);
    return ((int'(color) * PIECES + int'(piece)) * SQUARES + int'(square)) * HIDDEN;
  endfunction

  // Applies one accepted command to the checker state. Returns 1 when the command
  // answers with a sum, which is then in sum.
  function automatic bit apply_command(input acc_cmd_t c,
                                       output logic signed [SUM_WIDTH-1:0] sum);
    int from_base;
    int to_base;
    int fitted;
    bit piece_ok;
    piece_ok = int'(c.piece) < PIECES;
    from_base = row_base(c.color, c.piece, c.square);
    to_base = row_base(c.color, c.piece, c.to_square);
    sum = '0;
    apply_command = 1'b0;
    case (c.command)
      CMD_CLEAR: begin
        foreach (acc_model[i]) acc_model[i] = 0;
      end
      CMD_WRITE: begin
        // Keep the low WWIDTH bits of the sign-extended value, signed from there.
        fitted = int'(c.weight_value);
        fitted = (fitted <<< (32 - WWIDTH)) >>> (32 - WWIDTH);
        if (piece_ok && int'(c.lane) < HIDDEN) weight_model[from_base + int'(c.lane)] = fitted;
      end
      CMD_ADD, CMD_REMOVE: begin
        if (piece_ok) begin
          for (int i = 0; i < HIDDEN; i++) begin
            if (c.command == CMD_ADD) acc_model[i] += weight_model[from_base + i];
            else acc_model[i] -= weight_model[from_base + i];
          end
        end
      end
      CMD_MOVE: begin
        if (piece_ok) begin
          for (int i = 0; i < HIDDEN; i++) begin
            acc_model[i] = acc_model[i] + weight_model[to_base + i]
                           - weight_model[from_base + i];
          end
        end
      end
      CMD_READ: begin
        sum = (int'(c.lane) < HIDDEN) ? acc_model[c.lane] : 0;
        apply_command = 1'b1;
      end
      default: begin
      end
    endcase
  endfunction

  // Offers one item, with random gaps ahead of it, and waits until the block takes it.
  // A read queues either its typed answer or the predicted one.
  task automatic issue(input acc_cmd_t c, input bit use_fixed,
                       input logic signed [SUM_WIDTH-1:0] fixed_sum);
    logic signed [SUM_WIDTH-1:0] sum;
    while ($urandom_range(99) < send_gap_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.command <= c.command;
    cmd_bus.color <= c.color;
    cmd_bus.piece <= c.piece;
    cmd_bus.square <= c.square;
    cmd_bus.to_square <= c.to_square;
    cmd_bus.lane <= c.lane;
    cmd_bus.weight_value <= c.weight_value;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    if (apply_command(c, sum)) pending_sums.push_back(use_fixed ? fixed_sum : sum);
  endtask

  // Random traffic. Most commands work on the fully written rows; the rest are
  // writes anywhere, invalid pieces, clears, the unused codes and reads of any lane. Unused fields stay random.
  function automatic acc_cmd_t random_command();
    acc_cmd_t c;
    int pick;
    int k;
    int j;
    c.command = CMD_W'($urandom);
    c.color = 1'($urandom);
    c.piece = PIECE_W'($urandom);
    c.square = SQ_W'($urandom);
    c.to_square = SQ_W'($urandom);
    c.lane = LANE_W'($urandom);
    c.weight_value = WVAL_W'($urandom);
    pick = int'($urandom_range(99));
    k = int'($urandom_range(FULL_ROWS - 1));
    j = int'($urandom_range(1));
    if (pick < 25) begin
      c.command = CMD_READ;
    end else if (pick < 60) begin
      c.command = (pick < 45) ? CMD_ADD : CMD_REMOVE;
      c.color = full_color[k];
      c.piece = full_piece[k];
      c.square = full_square[k];
    end else if (pick < 72) begin
      c.command = CMD_MOVE;
      if ($urandom_range(2) == 0) begin
        // A piece that stays on its square.
        c.color = full_color[k];
        c.piece = full_piece[k];
        c.square = full_square[k];
        c.to_square = full_square[k];
      end else begin
        c.color = full_color[2];
        c.piece = full_piece[2];
        c.square = full_square[2 + j];
        c.to_square = full_square[3 - j];
      end
    end else if (pick < 80) begin
      c.command = CMD_WRITE;
      c.color = full_color[k];
      c.piece = full_piece[k];
      c.square = full_square[k];
    end else if (pick < 85) begin
      c.command = CMD_WRITE;
    end else if (pick < 90) begin
      c.command = (j == 0) ? CMD_ADD : ((k < 2) ? CMD_REMOVE : CMD_MOVE);
      c.piece = PIECE_W'(PIECES + j);
    end else if (pick < 94) begin
      c.command = CMD_CLEAR;
    end else begin
      c.command = (j == 0) ? CMD_SPARE_6 : CMD_SPARE_7;
    end
    return c;
  endfunction

  // Result side. The ready line follows the stall rate of the phase, except during a
  // hold-off, which this process counts down on its own.
  initial begin
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        res_bus.ready <= 1'b0;
        hold_cycles--;
      end else begin
        res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Every accepted sum is matched against the oldest one still owed.
  always @(posedge clk) begin
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: sum %0d arrived with none expected", $time, res_bus.sum_value);
        error_count++;
      end else begin
        expected_sum = pending_sums.pop_front();
        if (res_bus.sum_value !== expected_sum) begin
          $display("%0t: sum_value expected %0d, got %0d", $time, expected_sum,
                   res_bus.sum_value);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d sums still owed", $time, pending_sums.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    acc_cmd_t c;
    rst_n <= 1'b0;
    cmd_bus.valid <= 1'b0;
    cmd_bus.command <= CMD_CLEAR;
    cmd_bus.color <= 1'b0;
    cmd_bus.piece <= '0;
    cmd_bus.square <= '0;
    cmd_bus.to_square <= '0;
    cmd_bus.lane <= '0;
    cmd_bus.weight_value <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every lane of the full rows, so that no add, remove or move ever reads a
    // weight that was never written. The extremes of the weight range sit at the ends.
    for (int r = 0; r < FULL_ROWS; r++) begin
      for (int l = 0; l < HIDDEN; l++) begin
        c.command = CMD_WRITE;
        c.color = full_color[r];
        c.piece = full_piece[r];
        c.square = full_square[r];
        c.to_square = SQ_W'($urandom);
        c.lane = LANE_W'(l);
        c.weight_value = WVAL_W'($urandom);
        if (r == 0 && l == 0) c.weight_value = 16'h7fff;
        if (r == 1 && l == HIDDEN - 1) c.weight_value = 16'h8000;
        if (r == 2 && l == 0) c.weight_value = 16'h8000;
        if (r == 3 && l == HIDDEN - 1) c.weight_value = 16'h7fff;
        issue(c, 1'b0, '0);
      end
    end

    // Directed commands with light idling on both sides.
    send_gap_pct = 11;
    recv_stall_pct = 11;
    foreach (script[i]) issue(script[i].cmd, script[i].fixed, script[i].sum);

    // Random traffic in four idling phases: none, sender gaps, receiver stalls, both.
    for (int phase = 0; phase < 4; phase++) begin
      send_gap_pct = (phase == 1) ? 52 : ((phase == 3) ? 11 : 0);
      recv_stall_pct = (phase == 2) ? 52 : ((phase == 3) ? 11 : 0);
      if (phase == 2) begin
        // Long receiver hold-off while reads keep coming: the first sum parks in the
        // output register and the next read has to stall the command channel.
        hold_cycles = HOLD_OFF_CYCLES;
        repeat (6) begin
          c = random_command();
          c.command = CMD_READ;
          issue(c, 1'b0, '0);
        end
      end
      repeat (RANDOM_PER_PHASE) issue(random_command(), 1'b0, '0);
    end

    cmd_bus.valid <= 1'b0;
    recv_stall_pct = 0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
design/nnua_pkg.sv
design/nnua_if.sv
design/nnua_weight_mem.sv
design/nnua_sum_mem.sv
design/nnue_accumulator_update.sv
verif/testbench.sv
